@@ design/tsjs_pkg.sv @@
package tsjs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int WORK_BITS   = 8;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int CREDIT_W    = (WORK_BITS > 8) ? WORK_BITS : 8;
	localparam int SLICE_RESET = 5;

	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [WORK_BITS-1:0] work_t;
	typedef logic [CREDIT_W-1:0] credit_t;

	localparam logic REQ_ENQUEUE = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_DONE
	} tsjs_state_t;

	// One result beat as the control unit hands it to the output stage.
	typedef struct packed {
		logic       dropped;
		logic [4:0] level;
		logic [7:0] remaining;
		logic       busy;
	} res_t;

	// Job store access from the control unit.
	typedef struct packed {
		logic  wr_en;
		ptr_t  wr_addr;
		work_t wr_data;
		logic  rd_en;
		ptr_t  rd_addr;
	} mem_req_t;

endpackage

@@ design/tsjs_ram.sv @@
module tsjs_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/tsjs_ctrl.sv @@
module tsjs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_kind,
	input  logic [7:0]         in_work,
	output tsjs_pkg::mem_req_t mem_req,
	input  tsjs_pkg::work_t    mem_rdata,
	input  logic               out_free,
	output logic               res_load,
	output tsjs_pkg::res_t     res
);

	tsjs_pkg::tsjs_state_t state_q, state_nx;

	logic [7:0]        slice_q;
	tsjs_pkg::ptr_t    head_q, tail_q;
	tsjs_pkg::cnt_t    count_q;
	tsjs_pkg::work_t   job_left_q;
	tsjs_pkg::credit_t credit_q;
	logic              busy_q;
	logic              dropped_q;

	logic              in_fire;
	logic              is_enq;
	logic              full;
	logic              empty;
	tsjs_pkg::credit_t left_ext;
	logic              gt, eq;
	tsjs_pkg::ptr_t    head_nx, tail_nx;

	assign in_fire  = in_valid && in_ready;
	assign is_enq   = (in_kind == tsjs_pkg::REQ_ENQUEUE);
	assign full     = (count_q >= tsjs_pkg::cnt_t'(tsjs_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign left_ext = tsjs_pkg::credit_t'(job_left_q);
	assign gt       = (left_ext > credit_q);
	assign eq       = (left_ext == credit_q);
	assign head_nx  = (head_q == tsjs_pkg::ptr_t'(tsjs_pkg::QUEUE_DEPTH - 1)) ?
		'0 : head_q + tsjs_pkg::ptr_t'(1);
	assign tail_nx  = (tail_q == tsjs_pkg::ptr_t'(tsjs_pkg::QUEUE_DEPTH - 1)) ?
		'0 : tail_q + tsjs_pkg::ptr_t'(1);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tsjs_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_nx = is_enq ? tsjs_pkg::ST_DONE : tsjs_pkg::ST_EVAL;
				end
			end
			tsjs_pkg::ST_EVAL: begin
				if (gt || eq || empty) begin
					state_nx = tsjs_pkg::ST_DONE;
				end else begin
					state_nx = tsjs_pkg::ST_READ;
				end
			end
			tsjs_pkg::ST_READ: state_nx = tsjs_pkg::ST_EVAL;
			tsjs_pkg::ST_DONE: begin
				if (out_free) begin
					state_nx = tsjs_pkg::ST_IDLE;
				end
			end
			default: state_nx = tsjs_pkg::ST_IDLE;
		endcase
	end

	// Only one item is in work at a time and every push completes in its accept
	// cycle, so a read of the store never overlaps a write to the same entry.
	always_comb begin
		in_ready        = 1'b0;
		res_load        = 1'b0;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = tail_q;
		mem_req.wr_data = tsjs_pkg::work_t'(in_work);
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = head_q;
		case (state_q)
			tsjs_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mem_req.wr_en = in_valid && is_enq && !full;
			end
			tsjs_pkg::ST_EVAL: mem_req.rd_en = !gt && !eq && !empty;
			tsjs_pkg::ST_READ: ;
			tsjs_pkg::ST_DONE: res_load = out_free;
			default: ;
		endcase
	end

	assign res.busy      = busy_q;
	assign res.remaining = 8'(job_left_q);
	assign res.level     = 5'(count_q);
	assign res.dropped   = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= 8'(tsjs_pkg::SLICE_RESET);
		end else if (cfg_we) begin
			slice_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			job_left_q <= '0;
			busy_q     <= 1'b0;
			dropped_q  <= 1'b0;
			credit_q   <= '0;
		end else begin
			case (state_q)
				tsjs_pkg::ST_IDLE: begin
					if (in_fire) begin
						dropped_q <= 1'b0;
						if (is_enq) begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								tail_q  <= tail_nx;
								count_q <= count_q + tsjs_pkg::cnt_t'(1);
							end
						end else begin
							credit_q <= tsjs_pkg::credit_t'(slice_q);
						end
					end
				end
				tsjs_pkg::ST_EVAL: begin
					if (gt) begin
						job_left_q <= job_left_q - tsjs_pkg::work_t'(credit_q);
						busy_q     <= 1'b1;
					end else if (eq) begin
						job_left_q <= '0;
						busy_q     <= 1'b0;
					end else begin
						credit_q <= credit_q - left_ext;
						if (empty) begin
							job_left_q <= '0;
							busy_q     <= 1'b0;
						end else begin
							head_q  <= head_nx;
							count_q <= count_q - tsjs_pkg::cnt_t'(1);
						end
					end
				end
				tsjs_pkg::ST_READ: begin
					job_left_q <= mem_rdata;
					busy_q     <= 1'b1;
				end
				tsjs_pkg::ST_DONE: ;
				default: ;
			endcase
		end
	end

endmodule

@@ design/time_slice_job_server_unit.sv @@
// An enqueue beat passes from accept to the done state and then into the m_axis
// output register; a tick beat passes through evaluate, a read/evaluate pass per
// popped job, and done. One beat is in work at a time; a tick is paced by the loop
// around the single job store read port, and done waits for a free output register.
// A new beat is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous): empty queue, no job in service, slice length 5.
module time_slice_job_server_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] job_work
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] server_busy, [8:1] current_remaining,
	                                   // [13:9] queue_level, [14] job_dropped, [15] zero
);

	tsjs_pkg::mem_req_t mem_req;
	tsjs_pkg::work_t    mem_rdata;
	tsjs_pkg::res_t     res;
	logic               res_load;
	logic               out_free;
	logic               m_valid_q;
	logic [15:0]        m_data_q;

	assign out_free = !m_valid_q || m_axis_tready;

	tsjs_ram #(
		.DEPTH (tsjs_pkg::QUEUE_DEPTH),
		.WIDTH (tsjs_pkg::WORK_BITS),
		.AW    (tsjs_pkg::PTR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rdata)
	);

	tsjs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_work   (s_axis_tdata),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_data_q <= {1'b0, res};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

@@ design/tsjs_checker.sv @@
module tsjs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// One beat is in work at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a beat is in work");

	// The server is busy exactly when work is left on its job.
	a_busy_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[8:1] != 8'd0)))
		else $error("busy flag disagrees with remaining work");

	// A dropped job means the queue was full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[13:9] == 5'd16)
		else $error("job dropped with room in the queue");

endmodule

bind time_slice_job_server_unit tsjs_checker u_tsjs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
